[rtl/core/plt_pkg.sv]
// Package for the palette table: operation and status codes, the
// controller/datapath command and status structs, and the colour word helpers.
// No dependencies.
package plt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_GET    = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;
    localparam logic [2:0] OP_MARK   = 3'd5;
    localparam logic [2:0] OP_EXPORT = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_UNUSED  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic take;   // latch the item, clear the entry counter
        logic rd;     // read one entry
        logic act;    // perform a non-reading op and load the result
        logic load;   // load the result from the entry just read
        logic step;   // advance the entry counter
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic read_op;
        logic is_find;
        logic is_export;
        logic hit;
        logic cnt_last;
    } t_sts;

    // floor(c * 14 / 255): divide by 255 through the reciprocal form
    // (x + (x >> 8) + 1) >> 8, exact for the range of c * 14.
    function automatic logic [3:0] nib(input logic [7:0] c);
        logic [11:0] x;
        logic [12:0] s;
        x = {c, 4'b0000} - {3'b000, c, 1'b0};
        s = {1'b0, x} + {5'b00000, x[11:8]} + 13'd1;
        return s[11:8];
    endfunction

    // Pack blue, green, red nibbles
    function automatic logic [11:0] hw_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        return {nib(b), nib(g), nib(r)};
    endfunction

endpackage

[rtl/core/plt_ctrl.sv]
// Controller for the palette table: sequences accept, entry reads, result
// hand-off and the export and find walks. Uses plt_pkg.
module plt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  plt_pkg::t_sts i_sts,
    output plt_pkg::t_cmd o_cmd
);
    import plt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.read_op) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EVAL;
                end else begin
                    o_cmd.act = 1'b1;
                    n_state   = S_OUT;
                end
            end
            S_EVAL: begin
                // keep scanning until a hit or the last entry
                if (i_sts.is_find && !i_sts.hit && !i_sts.cnt_last) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end else begin
                    o_cmd.load = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (i_sts.is_export && !i_sts.cnt_last) begin
                        o_cmd.step = 1'b1;
                        n_state    = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

[rtl/core/plt_dp.sv]
// Datapath for the palette table: item registers, colour memory with
// per-entry black flags, used mask, entry counter and result registers.
// Uses plt_pkg.
module plt_dp #(
    parameter int ENTRIES = plt_pkg::ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  plt_pkg::t_cmd i_cmd,
    output plt_pkg::t_sts o_sts,
    input  logic [2:0]    i_op,
    input  logic [3:0]    i_index,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    output logic [1:0]    o_status,
    output logic [3:0]    o_slot,
    output logic [7:0]    o_out_red,
    output logic [7:0]    o_out_green,
    output logic [7:0]    o_out_blue,
    output logic [11:0]   o_hw_word,
    output logic [15:0]   o_used_mask,
    output logic          o_last
);
    import plt_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    // item registers
    logic [2:0]  r_op;
    logic [3:0]  r_idx;
    logic [7:0]  r_red, r_green, r_blue;
    logic [AW-1:0] r_cnt;

    // storage
    logic [23:0]        mem [ENTRIES];
    logic [ENTRIES-1:0] r_cval;
    logic [ENTRIES-1:0] r_used;
    logic [23:0]        r_rd;
    logic               r_rd_ok;

    // result registers
    logic [1:0]  r_status;
    logic [3:0]  r_slot;
    logic [7:0]  r_ored, r_ogreen, r_oblue;
    logic [11:0] r_word;
    logic [15:0] r_mask;
    logic        r_last;

    logic          in_range;
    logic [AW-1:0] idx_a;
    logic [11:0]   q_word;
    logic [23:0]   rd_col;
    logic [11:0]   rd_word;
    logic          free_found;
    logic [AW-1:0] free_idx;
    logic [AW-1:0] raddr;
    logic          mem_we;
    logic [AW-1:0] waddr;
    logic [ENTRIES-1:0] n_used;
    logic [ENTRIES-1:0] n_cval;
    logic [15:0]   mask_ext;
    logic [15:0]   n_mask_ext;
    logic          cnt_last;
    logic          hit;

    assign in_range = ({1'b0, r_idx} < 5'(ENTRIES));
    assign idx_a    = r_idx[AW-1:0];
    assign q_word   = hw_of(r_red, r_green, r_blue);
    assign rd_col   = r_rd_ok ? r_rd : 24'd0;
    assign rd_word  = hw_of(rd_col[23:16], rd_col[15:8], rd_col[7:0]);
    assign cnt_last = (r_cnt == AW'(ENTRIES - 1));
    assign hit      = r_used[r_cnt] && (rd_word == q_word);
    assign raddr    = (r_op == OP_GET) ? idx_a : r_cnt;

    // lowest free entry
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    // next used mask, black flags and memory write for the non-reading ops
    always_comb begin
        n_used = r_used;
        n_cval = r_cval;
        mem_we = 1'b0;
        waddr  = idx_a;
        case (r_op)
            OP_CLEAR: begin
                n_cval = '0;
            end
            OP_ADD: begin
                waddr = free_idx;
                if (free_found) begin
                    mem_we           = 1'b1;
                    n_used[free_idx] = 1'b1;
                    n_cval[free_idx] = 1'b1;
                end
            end
            OP_SET: begin
                if (in_range) begin
                    mem_we        = 1'b1;
                    n_used[idx_a] = 1'b1;
                    n_cval[idx_a] = 1'b1;
                end
            end
            OP_MARK: begin
                if (in_range) begin
                    n_used[idx_a] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mask_ext               = '0;
        mask_ext[ENTRIES-1:0]  = r_used;
        n_mask_ext             = '0;
        n_mask_ext[ENTRIES-1:0] = n_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_cval <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.act) begin
                r_used <= n_used;
                r_cval <= n_cval;
            end
            if (i_cmd.take) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= i_op;
            r_idx   <= i_index;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    // colour memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.act && mem_we) begin
            mem[waddr] <= {r_red, r_green, r_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd    <= mem[raddr];
            r_rd_ok <= r_cval[raddr];
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.act) begin
            r_ored   <= '0;
            r_ogreen <= '0;
            r_oblue  <= '0;
            r_last   <= 1'b1;
            r_mask   <= n_mask_ext;
            case (r_op)
                OP_ADD: begin
                    r_status <= free_found ? ST_OK : ST_MISS;
                    r_slot   <= free_found ? 4'(free_idx) : 4'd0;
                    r_word   <= free_found ? q_word : 12'd0;
                end
                OP_SET: begin
                    r_status <= in_range ? ST_OK : ST_MISS;
                    r_slot   <= r_idx;
                    r_word   <= in_range ? q_word : 12'd0;
                end
                OP_MARK: begin
                    r_status <= in_range ? ST_OK : ST_MISS;
                    r_slot   <= r_idx;
                    r_word   <= '0;
                end
                default: begin
                    r_status <= ST_OK;
                    r_slot   <= '0;
                    r_word   <= '0;
                end
            endcase
        end else if (i_cmd.load) begin
            r_mask   <= mask_ext;
            r_ored   <= '0;
            r_ogreen <= '0;
            r_oblue  <= '0;
            r_last   <= 1'b1;
            case (r_op)
                OP_GET: begin
                    r_slot <= r_idx;
                    if (in_range && r_used[idx_a]) begin
                        r_status <= ST_OK;
                        r_ored   <= rd_col[23:16];
                        r_ogreen <= rd_col[15:8];
                        r_oblue  <= rd_col[7:0];
                        r_word   <= rd_word;
                    end else begin
                        r_status <= ST_UNUSED;
                        r_word   <= '0;
                    end
                end
                OP_FIND: begin
                    r_status <= hit ? ST_OK : ST_MISS;
                    r_slot   <= hit ? 4'(r_cnt) : 4'd0;
                    r_word   <= q_word;
                end
                default: begin
                    // export
                    r_status <= ST_OK;
                    r_slot   <= 4'(r_cnt);
                    r_word   <= rd_word;
                    r_last   <= cnt_last;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.read_op   = (r_op == OP_GET) || (r_op == OP_FIND) || (r_op == OP_EXPORT);
        o_sts.is_find   = (r_op == OP_FIND);
        o_sts.is_export = (r_op == OP_EXPORT);
        o_sts.hit       = hit;
        o_sts.cnt_last  = cnt_last;
    end

    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_out_red   = r_ored;
    assign o_out_green = r_ogreen;
    assign o_out_blue  = r_oblue;
    assign o_hw_word   = r_word;
    assign o_used_mask = r_mask;
    assign o_last      = r_last;

endmodule

[rtl/core/palette_table_with_allocation.sv]
// Palette table with allocation: top level, joins plt_ctrl and plt_dp.
// From acceptance, clear, add, set and mark used pass through an action state to the output
// state; get reads the entry, evaluates it and outputs; find repeats read and evaluate per entry
// until a hit or the last entry; export reads, evaluates and outputs each entry in turn.
// One item at a time: the next item is accepted the cycle after its last result is taken.
// Reset (synchronous, active low) empties the used mask and marks every entry black at once.
module palette_table_with_allocation #(
    parameter int ENTRIES = plt_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [11:0] o_hw_word,
    output logic [15:0] o_used_mask,
    output logic        o_last
);
    import plt_pkg::*;

    // command and status between the sequencer and the datapath
    t_cmd cmd;
    t_sts sts;

    // Sequencer: accept, read entries one at a time, hold each result
    // in the output register until it is taken.
    plt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: colour memory, used mask, hardware word conversion
    // and result registers.
    plt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_hw_word   (o_hw_word),
        .o_used_mask (o_used_mask),
        .o_last      (o_last)
    );

endmodule
